[sv/jetc_pkg.sv]
// Shared types, constants and helpers of the Julia escape-time colorizer.
`timescale 1ns / 1ps
package jetc_pkg;

  localparam int WORD_W  = 32;
  localparam int ITER_W  = 12;
  localparam int PIX_W   = 12;
  localparam int COLOR_W = 24;
  localparam int CFG_IDX_W = 3;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MAX_ITER = 3'd0,
    REG_C_REAL   = 3'd1,
    REG_C_IMAG   = 3'd2,
    REG_ORIGIN_X = 3'd3,
    REG_ORIGIN_Y = 3'd4,
    REG_STEP_X   = 3'd5,
    REG_STEP_Y   = 3'd6
  } reg_idx_t;

  typedef struct packed {
    logic        [ITER_W-1:0] max_iterations;
    logic signed [WORD_W-1:0] c_real;
    logic signed [WORD_W-1:0] c_imag;
    logic signed [WORD_W-1:0] origin_x;
    logic signed [WORD_W-1:0] origin_y;
    logic signed [WORD_W-1:0] step_x;
    logic signed [WORD_W-1:0] step_y;
  } cfg_t;

  // Start point handed from the front end to the iteration engine
  typedef struct packed {
    logic signed [WORD_W-1:0] re;
    logic signed [WORD_W-1:0] im;
  } point_t;

  localparam cfg_t CFG_RESET = '{
    max_iterations: 12'd300,
    c_real:         -32'sd187904819,
    c_imag:         32'sd72517838,
    origin_x:       -32'sd402653184,
    origin_y:       -32'sd268435456,
    step_x:         32'sd1258291,
    step_y:         32'sd1118481
  };

  // Saturation bounds of a 32-bit word, in the wide intermediate format
  localparam int SAT_W = 66;
  localparam logic signed [SAT_W-1:0] SAT_HI = 66'sh0_7FFF_FFFF;
  localparam logic signed [SAT_W-1:0] SAT_LO = -66'sh0_8000_0000;
  localparam logic signed [WORD_W-1:0] WORD_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [WORD_W-1:0] WORD_MIN = 32'sh8000_0000;

  // Hue wheel: count mod 360 by reciprocal multiply, 60-degree sectors
  localparam int HUE_W = 9;
  localparam logic [ITER_W-1:0] HUE_MOD   = 12'd360;
  localparam logic [ITER_W-1:0] HUE_RECIP = 12'd2913;
  localparam int HUE_SHIFT = 20;
  localparam int HUE_QUOT_W = 4;
  localparam logic [HUE_W-1:0] HUE_SECTOR = 9'd60;
  localparam logic [7:0] CHAN_MAX = 8'hFF;

  // Clamp a wide signed value to the 32-bit word range
  function automatic logic signed [WORD_W-1:0] sat_word(input logic signed [SAT_W-1:0] v);
    logic signed [WORD_W-1:0] r;
    if (v > SAT_HI) begin
      r = WORD_MAX;
    end else if (v < SAT_LO) begin
      r = WORD_MIN;
    end else begin
      r = v[WORD_W-1:0];
    end
    return r;
  endfunction

endpackage

[sv/jetc_if.sv]
// Valid/ready channel interfaces for pixel coordinates and colored results.
`timescale 1ns / 1ps
interface jetc_pix_if;
  logic                       valid;
  logic                       ready;
  logic [jetc_pkg::PIX_W-1:0] pixel_x;
  logic [jetc_pkg::PIX_W-1:0] pixel_y;
  modport source (output valid, pixel_x, pixel_y, input ready);
  modport sink   (input valid, pixel_x, pixel_y, output ready);
endinterface

interface jetc_res_if;
  logic                         valid;
  logic                         ready;
  logic [jetc_pkg::COLOR_W-1:0] color;
  logic [jetc_pkg::ITER_W-1:0]  iteration_count;
  modport source (output valid, color, iteration_count, input ready);
  modport sink   (input valid, color, iteration_count, output ready);
endinterface

[sv/jetc_front.sv]
// Front end: accepts a pixel and maps it to its start point in the plane.
`timescale 1ns / 1ps
module jetc_front #(
  parameter int COORD_BITS = 12
) (
  input  logic             clk,
  input  logic             rst,
  input  jetc_pkg::cfg_t   cfg,
  jetc_pix_if.sink         pix,
  output logic             push_valid,
  input  logic             push_ready,
  output jetc_pkg::point_t push_data
);
  import jetc_pkg::*;

  localparam int PW = COORD_BITS + WORD_W + 1;

  typedef enum logic [2:0] {
    F_IDLE = 3'b001,
    F_MUL  = 3'b010,
    F_PUSH = 3'b100
  } fstate_t;

  fstate_t state, state_next;
  logic [COORD_BITS-1:0] px, py;
  logic signed [PW-1:0]  prod_x, prod_y;
  logic signed [PW:0]    sum_x, sum_y;

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      F_IDLE:  if (pix.valid) state_next = F_MUL;
      F_MUL:   state_next = F_PUSH;
      F_PUSH:  if (push_ready) state_next = F_IDLE;
      default: state_next = F_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= F_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Latch the used coordinate bits, then form the scaled offsets
  always_ff @(posedge clk) begin
    if (state == F_IDLE && pix.valid) begin
      px <= COORD_BITS'({{COORD_BITS{1'b0}}, pix.pixel_x});
      py <= COORD_BITS'({{COORD_BITS{1'b0}}, pix.pixel_y});
    end
    if (state == F_MUL) begin
      prod_x <= $signed({1'b0, px}) * cfg.step_x;
      prod_y <= $signed({1'b0, py}) * cfg.step_y;
    end
  end

  // Add the origin and clamp
  always_comb begin
    sum_x = (PW+1)'(prod_x) + (PW+1)'(cfg.origin_x);
    sum_y = (PW+1)'(prod_y) + (PW+1)'(cfg.origin_y);
    push_data.re = sat_word(SAT_W'(sum_x));
    push_data.im = sat_word(SAT_W'(sum_y));
  end

  assign pix.ready  = (state == F_IDLE);
  assign push_valid = (state == F_PUSH);

`ifndef SYNTHESIS
  a_push_holds: assert property (@(posedge clk) disable iff (rst)
    (state == F_PUSH && !push_ready) |=> (state == F_PUSH && !pix.ready))
    else $error("front dropped a start point while the queue was full");
`endif

endmodule

[sv/jetc_fifo.sv]
// Short queue of start points between the front end and the iteration engine.
`timescale 1ns / 1ps
module jetc_fifo #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push_valid,
  output logic             push_ready,
  input  logic [WIDTH-1:0] push_data,
  output logic             pop_valid,
  input  logic             pop,
  output logic [WIDTH-1:0] pop_data
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr, rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_push, do_pop;

  assign push_ready = (count != CNT_FULL);
  assign pop_valid  = (count != '0);
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop && pop_valid;
  assign pop_data   = mem[rd_ptr];

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) wr_ptr <= (wr_ptr == PTR_LAST) ? '0 : wr_ptr + 1'b1;
      if (do_pop)  rd_ptr <= (rd_ptr == PTR_LAST) ? '0 : rd_ptr + 1'b1;
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

  // Store the entry
  always_ff @(posedge clk) begin
    if (do_push) mem[wr_ptr] <= push_data;
  end

`ifndef SYNTHESIS
  a_fill: assert property (@(posedge clk) disable iff (rst)
    (do_push && !do_pop) |=> (count == CNT_W'($past(count) + 1'b1)))
    else $error("queue occupancy did not grow on a lone push");
  a_no_underrun: assert property (@(posedge clk) disable iff (rst)
    pop |-> (count != '0 && count <= CNT_FULL))
    else $error("queue popped while empty");
`endif

endmodule

[sv/jetc_back.sv]
// Iteration engine: runs z = z*z + c on one start point and colors the result.
`timescale 1ns / 1ps
module jetc_back #(
  parameter int FRAC_BITS = 28
) (
  input  logic             clk,
  input  logic             rst,
  input  jetc_pkg::cfg_t   cfg,
  input  logic             q_valid,
  input  jetc_pkg::point_t q_data,
  output logic             q_pop,
  jetc_res_if.source       res
);
  import jetc_pkg::*;

  // Escape when |z|^2 > 4, i.e. the exact sum of squares exceeds 2^(2F+2)
  localparam int SH = 2 * FRAC_BITS + 2;
  localparam bit ESC_ON = (SH < 64);
  localparam logic [64:0] ESC_LIMIT = ESC_ON ? (65'd1 << SH) : 65'd0;

  typedef enum logic [4:0] {
    B_IDLE = 5'b00001,
    B_MUL  = 5'b00010,
    B_UPD  = 5'b00100,
    B_HUE  = 5'b01000,
    B_OUT  = 5'b10000
  } bstate_t;

  bstate_t state, state_next;
  logic signed [WORD_W-1:0] re, im;
  logic signed [63:0]       rr, ii, ri;
  logic [ITER_W-1:0]        cnt;
  logic                     esc;
  logic [HUE_QUOT_W-1:0]    quot;

  logic [63:0]              esc_sum;
  logic                     esc_hit;
  logic                     at_limit;
  logic signed [63:0]       re_shr, im_shr;
  logic signed [WORD_W-1:0] nre, nim;
  logic [2*ITER_W-1:0]      hue_prod;
  logic [ITER_W-1:0]        hue;
  logic [COLOR_W-1:0]       color_next;
  logic                     out_free;

  // Map a hue in degrees to packed BGR at full saturation and value
  function automatic logic [COLOR_W-1:0] hue_color(input logic [HUE_W-1:0] h);
    logic [HUE_W-1:0] r;
    logic [7:0]       t, rd, gr, bl;
    if (h < HUE_SECTOR) begin
      r = h;
    end else if (h < 2 * HUE_SECTOR) begin
      r = h - HUE_SECTOR;
    end else if (h < 3 * HUE_SECTOR) begin
      r = HUE_W'(h - 2 * HUE_SECTOR);
    end else if (h < 4 * HUE_SECTOR) begin
      r = HUE_W'(h - 3 * HUE_SECTOR);
    end else if (h < 5 * HUE_SECTOR) begin
      r = HUE_W'(h - 4 * HUE_SECTOR);
    end else begin
      r = HUE_W'(h - 5 * HUE_SECTOR);
    end
    // 255 * r / 60 = 17 * r / 4
    t = 8'((10'(r) * 10'd17) >> 2);
    priority if (h < HUE_SECTOR) begin
      rd = CHAN_MAX;     gr = t;            bl = '0;
    end else if (h < 2 * HUE_SECTOR) begin
      rd = CHAN_MAX - t; gr = CHAN_MAX;     bl = '0;
    end else if (h < 3 * HUE_SECTOR) begin
      rd = '0;           gr = CHAN_MAX;     bl = t;
    end else if (h < 4 * HUE_SECTOR) begin
      rd = '0;           gr = CHAN_MAX - t; bl = CHAN_MAX;
    end else if (h < 5 * HUE_SECTOR) begin
      rd = t;            gr = '0;           bl = CHAN_MAX;
    end else begin
      rd = CHAN_MAX;     gr = '0;           bl = CHAN_MAX - t;
    end
    return {bl, gr, rd};
  endfunction

  // Update datapath from the registered products
  always_comb begin
    esc_sum  = $unsigned(rr) + $unsigned(ii);
    esc_hit  = ESC_ON && (cnt != '0) && ({1'b0, esc_sum} > ESC_LIMIT);
    at_limit = (cnt == cfg.max_iterations);
    re_shr   = (rr - ii) >>> FRAC_BITS;
    im_shr   = ri >>> (FRAC_BITS - 1);
    nre      = sat_word(SAT_W'(re_shr) + SAT_W'(cfg.c_real));
    nim      = sat_word(SAT_W'(im_shr) + SAT_W'(cfg.c_imag));
  end

  // Coloring: count mod 360 through the registered quotient
  always_comb begin
    hue_prod   = (2*ITER_W)'(cnt) * (2*ITER_W)'(HUE_RECIP);
    hue        = cnt - ITER_W'(ITER_W'(quot) * HUE_MOD);
    color_next = esc ? hue_color(HUE_W'(hue)) : '0;
    out_free   = !res.valid || res.ready;
  end

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      B_IDLE:  if (q_valid) state_next = B_MUL;
      B_MUL:   state_next = B_UPD;
      B_UPD:   if (esc_hit || at_limit) state_next = B_HUE;
               else state_next = B_MUL;
      B_HUE:   state_next = B_OUT;
      B_OUT:   if (out_free) state_next = B_IDLE;
      default: state_next = B_IDLE;
    endcase
  end

  assign q_pop = (state == B_IDLE) && q_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= B_IDLE;
      res.valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == B_OUT && out_free) begin
        res.valid <= 1'b1;
      end else if (res.ready) begin
        res.valid <= 1'b0;
      end
    end
  end

  // Iteration registers and result register
  always_ff @(posedge clk) begin
    unique case (state)
      B_IDLE: begin
        if (q_valid) begin
          re  <= q_data.re;
          im  <= q_data.im;
          cnt <= '0;
        end
      end
      B_MUL: begin
        rr <= re * re;
        ii <= im * im;
        ri <= re * im;
      end
      B_UPD: begin
        if (esc_hit) begin
          cnt <= cnt - 1'b1;
          esc <= 1'b1;
        end else if (at_limit) begin
          esc <= 1'b0;
        end else begin
          re  <= nre;
          im  <= nim;
          cnt <= cnt + 1'b1;
        end
      end
      B_HUE: begin
        quot <= HUE_QUOT_W'(hue_prod >> HUE_SHIFT);
      end
      B_OUT: begin
        if (out_free) begin
          res.color           <= color_next;
          res.iteration_count <= cnt;
        end
      end
      default: ;
    endcase
  end

`ifndef SYNTHESIS
  a_count_steps: assert property (@(posedge clk) disable iff (rst)
    (state == B_UPD && state_next == B_MUL) |=> (cnt == ITER_W'($past(cnt) + 1'b1)))
    else $error("update counter did not advance by one");
  a_escape_colored: assert property (@(posedge clk) disable iff (rst)
    (state == B_OUT && out_free && esc) |=> (res.valid && res.color != '0))
    else $error("escaped pixel came out black");
`endif

endmodule

[sv/julia_escape_time_colorizer_unit.sv]
// Top level of the Julia escape-time colorizer: configuration, front end, queue, engine.
`timescale 1ns / 1ps
// One pixel coordinate in, one colored result out. The front end maps the
// pixel to its start point (origin + index * step, saturated) and parks it
// in a short queue, so it takes further pixels while the engine works.
// Each update of z in the engine is a multiply step for the three products,
// then the shift, add and saturate that also checks escape on those
// products; at most max_iterations updates are done per pixel, and the
// engine is what sets the rate.
// Configuration registers are written through cfg_write/cfg_index/cfg_data and
// must only change while no pixel is in flight. No clearing pass after reset.
module julia_escape_time_colorizer_unit #(
  parameter int FRAC_BITS   = 28,
  parameter int COORD_BITS  = 12,
  parameter int QUEUE_DEPTH = 4
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_write,
  input  logic [jetc_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [jetc_pkg::WORD_W-1:0]    cfg_data,
  jetc_pix_if.sink                       pix,
  jetc_res_if.source                     res
);
  import jetc_pkg::*;

  cfg_t   cfg;
  logic   push_valid, push_ready;
  point_t push_data;
  logic   pop_valid, pop;
  point_t pop_data;

  // Configuration registers; writes to unknown indexes are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= CFG_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_MAX_ITER: cfg.max_iterations <= cfg_data[ITER_W-1:0];
        REG_C_REAL:   cfg.c_real         <= cfg_data;
        REG_C_IMAG:   cfg.c_imag         <= cfg_data;
        REG_ORIGIN_X: cfg.origin_x       <= cfg_data;
        REG_ORIGIN_Y: cfg.origin_y       <= cfg_data;
        REG_STEP_X:   cfg.step_x         <= cfg_data;
        REG_STEP_Y:   cfg.step_y         <= cfg_data;
        default: ;
      endcase
    end
  end

  jetc_front #(
    .COORD_BITS (COORD_BITS)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .pix        (pix),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data)
  );

  jetc_fifo #(
    .WIDTH (2 * WORD_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data),
    .pop_valid  (pop_valid),
    .pop        (pop),
    .pop_data   (pop_data)
  );

  jetc_back #(
    .FRAC_BITS (FRAC_BITS)
  ) u_back (
    .clk     (clk),
    .rst     (rst),
    .cfg     (cfg),
    .q_valid (pop_valid),
    .q_data  (pop_data),
    .q_pop   (pop),
    .res     (res)
  );

endmodule

[sim/tb.sv]
// Self-checking testbench for the Julia escape-time colorizer unit.
`timescale 1ns / 1ps
module tb;
  import jetc_pkg::*;

  localparam int FRAC = 28;
  localparam int LIMIT_CYCLES = 40_000_000;
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd7;
  localparam logic [31:0] Q_MIN = 32'h8000_0000;
  localparam logic [31:0] Q_MAX = 32'h7FFF_FFFF;
  localparam logic [31:0] Q_QUARTER = 32'h0400_0000;
  localparam logic [31:0] Q_NEG_HALF = 32'hF800_0000;
  localparam longint WORD_TOP = 64'sd2147483647;
  localparam longint WORD_BOTTOM = -64'sd2147483648;
  localparam logic [63:0] ESCAPE_RADIUS_SQ = 64'd1 << (2 * FRAC + 2);
  localparam int unsigned HUE_SECTOR = 60;
  localparam int unsigned HUE_TURN = 360;
  localparam int unsigned CHAN_FULL = 255;

  typedef struct {
    logic [COLOR_W-1:0] color;
    logic [ITER_W-1:0]  count;
  } shade_t;

  typedef enum int {RX_STEADY, RX_TOGGLE, RX_SPOTTY, RX_CHOKED} rx_mode_t;

  // Shadow registers plus the escape-time prediction for every accepted pixel
  class pixel_color_board;
    logic [ITER_W-1:0] lim;
    logic signed [31:0] cre, cim, ox, oy, sx, sy;
    shade_t expected_shades[$];
    int errors;

    function new();
      lim = 12'd300;
      cre = -32'sd187904819;
      cim = 32'sd72517838;
      ox = -32'sd402653184;
      oy = -32'sd268435456;
      sx = 32'sd1258291;
      sy = 32'sd1118481;
      errors = 0;
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] data);
      case (idx)
        REG_MAX_ITER: lim = data[ITER_W-1:0];
        REG_C_REAL:   cre = data;
        REG_C_IMAG:   cim = data;
        REG_ORIGIN_X: ox = data;
        REG_ORIGIN_Y: oy = data;
        REG_STEP_X:   sx = data;
        REG_STEP_Y:   sy = data;
        default: ;
      endcase
    endfunction

    function logic signed [31:0] clamp_word(longint v);
      if (v > WORD_TOP) return Q_MAX;
      if (v < WORD_BOTTOM) return Q_MIN;
      return v[31:0];
    endfunction

    // Iterate z = z*z + c from the mapped start point, then color the count
    function shade_t escape_time(logic [PIX_W-1:0] px, logic [PIX_W-1:0] py);
      longint rr, ii, ri;
      logic [63:0] mag;
      logic signed [31:0] zr, zi;
      int unsigned n, h, t, r, g, b;
      shade_t s;
      zr = clamp_word(longint'(ox) + longint'(px) * longint'(sx));
      zi = clamp_word(longint'(oy) + longint'(py) * longint'(sy));
      n = 0;
      while (n < lim) begin
        rr = longint'(zr) * longint'(zr);
        ii = longint'(zi) * longint'(zi);
        ri = longint'(zr) * longint'(zi);
        zr = clamp_word(((rr - ii) >>> FRAC) + longint'(cre));
        zi = clamp_word((ri >>> (FRAC - 1)) + longint'(cim));
        rr = longint'(zr) * longint'(zr);
        ii = longint'(zi) * longint'(zi);
        mag = rr + ii;
        if (mag > ESCAPE_RADIUS_SQ) break;
        n++;
      end
      s.count = n[ITER_W-1:0];
      s.color = '0;
      if (n < lim) begin
        h = n % HUE_TURN;
        t = CHAN_FULL * (h % HUE_SECTOR) / HUE_SECTOR;
        if (h < HUE_SECTOR) begin
          r = CHAN_FULL; g = t; b = 0;
        end else if (h < 2 * HUE_SECTOR) begin
          r = CHAN_FULL - t; g = CHAN_FULL; b = 0;
        end else if (h < 3 * HUE_SECTOR) begin
          r = 0; g = CHAN_FULL; b = t;
        end else if (h < 4 * HUE_SECTOR) begin
          r = 0; g = CHAN_FULL - t; b = CHAN_FULL;
        end else if (h < 5 * HUE_SECTOR) begin
          r = t; g = 0; b = CHAN_FULL;
        end else begin
          r = CHAN_FULL; g = 0; b = CHAN_FULL - t;
        end
        s.color = {b[7:0], g[7:0], r[7:0]};
      end
      return s;
    endfunction

    function void note_pixel(logic [PIX_W-1:0] px, logic [PIX_W-1:0] py);
      expected_shades.push_back(escape_time(px, py));
    endfunction

    function void check_result(logic [COLOR_W-1:0] color, logic [ITER_W-1:0] count);
      shade_t want;
      if (expected_shades.size() == 0) begin
        $error("result with no pixel pending: color %h count %0d", color, count);
        errors++;
        return;
      end
      want = expected_shades.pop_front();
      if (color !== want.color) begin
        $error("color mismatch: expected %h, got %h", want.color, color);
        errors++;
      end
      if (count !== want.count) begin
        $error("iteration_count mismatch: expected %0d, got %0d", want.count, count);
        errors++;
      end
    endfunction

    function int pending();
      return expected_shades.size();
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst;
  logic cfg_write;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [WORD_W-1:0] cfg_data;
  int cycle_count = 0;
  int burst_left = 0;
  int rx_left = 0;
  rx_mode_t rx_mode = RX_STEADY;
  int unsigned hue_eps[7] = '{2950000, 327000, 118000, 60000, 36000, 24000, 16600};
  pixel_color_board board = new();

  jetc_pix_if pix ();
  jetc_res_if res ();

  julia_escape_time_colorizer_unit dut (
    .clk(clk),
    .rst(rst),
    .cfg_write(cfg_write),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .pix(pix),
    .res(res)
  );

  always #10 clk = ~clk;

  // Abort a hung run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= LIMIT_CYCLES) begin
      $display("tb NOT OK");
      $finish;
    end
  end

  // Check every result beat against the oldest prediction
  always @(posedge clk) begin
    if (!rst && res.valid === 1'b1 && res.ready === 1'b1) begin
      board.check_result(res.color, res.iteration_count);
    end
  end

  // Stall the result side in changing patterns
  always @(negedge clk) begin
    if (rx_left == 0) begin
      rx_mode <= rx_mode_t'($urandom_range(0, 3));
      rx_left <= $urandom_range(20, 400);
    end else begin
      rx_left <= rx_left - 1;
    end
    case (rx_mode)
      RX_STEADY: res.ready <= 1'b1;
      RX_TOGGLE: res.ready <= ~res.ready;
      RX_SPOTTY: res.ready <= ($urandom_range(0, 3) != 0);
      default:   res.ready <= ($urandom_range(0, 15) == 0);
    endcase
  end

  task automatic pause(input int n);
    repeat (n) begin
      @(negedge clk);
      pix.valid <= 1'b0;
    end
  endtask

  // Send one pixel beat, inserting a gap whenever the current burst runs out
  task automatic feed(input logic [PIX_W-1:0] px, input logic [PIX_W-1:0] py);
    if (burst_left == 0) begin
      pause($urandom_range(1, 12));
      burst_left = $urandom_range(1, 40);
    end
    burst_left--;
    @(negedge clk);
    pix.valid <= 1'b1;
    pix.pixel_x <= px;
    pix.pixel_y <= py;
    do @(posedge clk); while (pix.ready !== 1'b1);
    board.note_pixel(px, py);
  endtask

  // Hold the sender until every predicted result has come back
  task automatic wait_for_results();
    pause(1);
    while (board.pending() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] data);
    @(negedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    board.set_reg(idx, data);
    @(negedge clk);
    cfg_write <= 1'b0;
  endtask

  function automatic logic [31:0] extreme_word();
    case ($urandom_range(0, 5))
      0: return Q_MIN;
      1: return Q_MAX;
      2: return 32'h0;
      3: return 32'hFFFF_FFFF;
      4: return 32'h1;
      default: return $urandom;
    endcase
  endfunction

  // One idle-time reconfiguration followed by a stream of random pixels
  task automatic run_random_phase(input int n);
    int mode, hold_at;
    logic signed [31:0] stx, sty;
    mode = $urandom_range(0, 9);
    if (mode < 7) begin
      // a centered window around the set, where orbits run longest
      stx = $urandom_range(100000, 300000);
      sty = $urandom_range(100000, 300000);
      if ($urandom_range(0, 1)) stx = -stx;
      if ($urandom_range(0, 1)) sty = -sty;
      write_reg(REG_MAX_ITER, $urandom_range(1, 120));
      write_reg(REG_C_REAL, int'($urandom_range(0, 536870912)) - 268435456);
      write_reg(REG_C_IMAG, int'($urandom_range(0, 536870912)) - 268435456);
      write_reg(REG_STEP_X, stx);
      write_reg(REG_STEP_Y, sty);
      write_reg(REG_ORIGIN_X, -(stx * 2048) + int'($urandom_range(0, 67108864)) - 33554432);
      write_reg(REG_ORIGIN_Y, -(sty * 2048) + int'($urandom_range(0, 67108864)) - 33554432);
    end else if (mode < 9) begin
      write_reg(REG_MAX_ITER, $urandom);
      write_reg(REG_C_REAL, $urandom);
      write_reg(REG_C_IMAG, $urandom);
      write_reg(REG_ORIGIN_X, $urandom);
      write_reg(REG_ORIGIN_Y, $urandom);
      write_reg(REG_STEP_X, $urandom);
      write_reg(REG_STEP_Y, $urandom);
    end else begin
      write_reg(REG_MAX_ITER, $urandom_range(0, 64));
      write_reg(REG_C_REAL, extreme_word());
      write_reg(REG_C_IMAG, extreme_word());
      write_reg(REG_ORIGIN_X, extreme_word());
      write_reg(REG_ORIGIN_Y, extreme_word());
      write_reg(REG_STEP_X, extreme_word());
      write_reg(REG_STEP_Y, extreme_word());
    end
    if ($urandom_range(0, 3) == 0) write_reg(REG_UNUSED, $urandom);
    hold_at = $urandom_range(0, n - 1);
    for (int i = 0; i < n; i++) begin
      if (i == hold_at) wait_for_results();
      feed($urandom_range(0, 4095), $urandom_range(0, 4095));
    end
    wait_for_results();
  endtask

  initial begin
    rst = 1'b1;
    cfg_write = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    pix.valid = 1'b0;
    pix.pixel_x = '0;
    pix.pixel_y = '0;
    res.ready = 1'b0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // reset view: corners, center, alternating bit patterns
    feed(12'd0, 12'd0);
    feed(12'd4095, 12'd4095);
    feed(12'd4095, 12'd0);
    feed(12'd0, 12'd4095);
    feed(12'd320, 12'd240);
    feed(12'd2048, 12'd2048);
    feed(12'd1, 12'd1);
    feed(12'hAAA, 12'h555);
    feed(12'h555, 12'hAAA);
    wait_for_results();

    // zero limit gives black at count zero; the spare index must not land anywhere
    write_reg(REG_MAX_ITER, 32'd0);
    write_reg(REG_UNUSED, 32'h0000_0123);
    feed(12'd0, 12'd0);
    feed(12'd4095, 12'd4095);
    wait_for_results();

    // full limit with an orbit pinned at zero
    write_reg(REG_MAX_ITER, 32'd4095);
    write_reg(REG_C_REAL, 32'd0);
    write_reg(REG_C_IMAG, 32'd0);
    write_reg(REG_ORIGIN_X, 32'd0);
    write_reg(REG_ORIGIN_Y, 32'd0);
    write_reg(REG_STEP_X, 32'd0);
    write_reg(REG_STEP_Y, 32'd0);
    feed(12'd4095, 12'd4095);
    wait_for_results();

    // constant at the word extremes puts z at the extremes on the first update
    write_reg(REG_C_REAL, Q_MIN);
    write_reg(REG_C_IMAG, Q_MAX);
    feed(12'd0, 12'd0);
    feed(12'd4095, 12'd0);
    wait_for_results();

    // extreme window: extreme origin and steps, some start points saturated, one update allowed
    write_reg(REG_MAX_ITER, 32'd1);
    write_reg(REG_C_REAL, 32'd0);
    write_reg(REG_C_IMAG, 32'd0);
    write_reg(REG_ORIGIN_X, Q_MIN);
    write_reg(REG_ORIGIN_Y, Q_MAX);
    write_reg(REG_STEP_X, Q_MAX);
    write_reg(REG_STEP_Y, Q_MIN);
    feed(12'd0, 12'd0);
    feed(12'd4095, 12'd4095);
    feed(12'd1, 12'd1);
    wait_for_results();

    // just past the cusp at c = 1/4 the escape time stretches out, sweeping all hues
    foreach (hue_eps[k]) begin
      write_reg(REG_MAX_ITER, 32'd1000);
      write_reg(REG_C_REAL, Q_QUARTER + hue_eps[k]);
      write_reg(REG_C_IMAG, 32'd0);
      write_reg(REG_ORIGIN_X, Q_NEG_HALF);
      write_reg(REG_ORIGIN_Y, 32'd0);
      write_reg(REG_STEP_X, 32'd72090);
      write_reg(REG_STEP_Y, 32'd16);
      repeat (12) feed($urandom_range(0, 4095), $urandom_range(0, 4095));
      wait_for_results();
    end

    repeat (20) run_random_phase(80);

    pause(1);
    while (board.pending() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (board.errors == 0) begin
      $display("tb OK");
    end else begin
      $display("tb NOT OK");
    end
    $finish;
  end

endmodule
